/* rtl/sctb_pkg.sv */
// Package with the shared types and constants of the code table builder.
`timescale 1ns / 1ps
package sctb_pkg;

   localparam int SYMBOL_BITS = 8;
   localparam int LEN_BITS    = 5;
   localparam int WORD_BITS   = 17;
   localparam int RANK_BITS   = 8;
   localparam int DIST_BITS   = 9;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } sctb_opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_WR,
      ST_RD_OUT,
      ST_B_FETCH,
      ST_B_CAPT,
      ST_B_SCAN,
      ST_B_DIV,
      ST_B_WAIT
   } sctb_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_LEN,
      DV_DIV
   } sctb_div_state_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]  len;
      logic [WORD_BITS-1:0] word;
   } sctb_code_type;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      sctb_code_type          code;
   } sctb_entry_type;

endpackage

/* rtl/sctb_hist.sv */
// Histogram store: count memory with per-entry valid bits that let a clear empty every entry at once.
`timescale 1ns / 1ps
module sctb_hist
   import sctb_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256,
   parameter int COUNT_BITS    = 16,
   localparam int SYM_W        = $clog2(ALPHABET_SIZE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic [SYM_W-1:0]      rd_addr,
   output logic [COUNT_BITS-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [SYM_W-1:0]      wr_addr,
   input  logic [COUNT_BITS-1:0] wr_data
);

   logic [COUNT_BITS-1:0]    mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   logic [COUNT_BITS-1:0]    rd_mem_ff;
   logic                     rd_valid_ff;

   // Valid bits: an entry never written since reset or clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Count memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_mem_ff   <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

endmodule

/* rtl/sctb_table.sv */
// Code table memory indexed by rank, one write and one registered read port.
`timescale 1ns / 1ps
module sctb_table
   import sctb_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256,
   localparam int SYM_W        = $clog2(ALPHABET_SIZE)
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [SYM_W-1:0] wr_addr,
   input  sctb_entry_type wr_data,
   input  logic           rd_en,
   input  logic [SYM_W-1:0] rd_addr,
   output sctb_entry_type rd_data
);

   sctb_entry_type mem [ALPHABET_SIZE];
   sctb_entry_type rd_data_ff;

   // Entries have no reset; a build writes every rank that can be read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sctb_div.sv */
// Shared shift and compare unit: finds the code length, then long-divides the code.
`timescale 1ns / 1ps
module sctb_div
   import sctb_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   localparam int LCW       = $clog2(COUNT_BITS + 2)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  kind,
   input  logic [COUNT_BITS-1:0] freq,
   input  logic [COUNT_BITS-1:0] cum,
   input  logic [COUNT_BITS-1:0] total,
   output logic                  done,
   output sctb_code_type         code
);

   sctb_div_state_type    state_ff, state_in;
   logic [COUNT_BITS:0]   fs_ff, fs_in;
   logic [LCW-1:0]        len_ff, len_in;
   logic [LCW-1:0]        bits_ff, bits_in;
   logic [LCW-1:0]        step_ff, step_in;
   logic [COUNT_BITS+1:0] rem_ff, rem_in;
   logic [COUNT_BITS:0]   den_ff, den_in;
   logic [WORD_BITS-1:0]  quo_ff, quo_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS+1:0] rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      fs_ff   <= fs_in;
      len_ff  <= len_in;
      bits_ff <= bits_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign rem_sh = {rem_ff[COUNT_BITS:0], 1'b0};

   // Length search doubles the count until it reaches the total; division
   // then produces one quotient bit per cycle.
   always_comb begin
      state_in = state_ff;
      fs_in    = fs_ff;
      len_in   = len_ff;
      bits_in  = bits_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               fs_in    = {1'b0, freq};
               len_in   = '0;
               state_in = DV_LEN;
            end
         end
         DV_LEN: begin
            if (fs_ff < {1'b0, total}) begin
               fs_in  = {fs_ff[COUNT_BITS-1:0], 1'b0};
               len_in = len_ff + LCW'(1);
            end else begin
               bits_in = len_ff + LCW'(kind);
               step_in = '0;
               quo_in  = '0;
               if (kind) begin
                  rem_in = {1'b0, cum, 1'b0} + {2'b00, freq};
                  den_in = {total, 1'b0};
               end else begin
                  rem_in = {2'b00, cum};
                  den_in = {1'b0, total};
               end
               state_in = DV_DIV;
            end
         end
         DV_DIV: begin
            if (step_ff == bits_ff) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               step_in = step_ff + LCW'(1);
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_in = rem_sh - {1'b0, den_ff};
                  quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
               end
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   assign done      = done_ff;
   assign code.word = quo_ff;
   assign code.len  = LEN_BITS'(bits_ff);

endmodule

/* rtl/shannon_code_table_builder.sv */
// Top level: sequencer for loads, table builds, reads and clears.
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  request | req_valid, req_stall, req_opcode/symbol/rank | in
//  result  | rsp_valid, rsp_stall, rsp_* fields           | out
//  config  | csr_valid, csr_ready, csr_code_kind          | in
//
// A load reads the count, then writes it back incremented; a dropped load and a
// clear finish in the idle state. A read goes through the table read port and
// may wait on the result register. A build fetches and captures the count of
// each symbol; for a symbol that occurs it then scans all ALPHABET_SIZE symbols
// and finds the code by length search and division, counting distinct symbols.
// Reset is synchronous and clears the histogram at once through valid bits;
// req_stall is high while a request is at work. A result waits in its register
// while rsp_stall holds.
`timescale 1ns / 1ps
module shannon_code_table_builder
   import sctb_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256,
   parameter int COUNT_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [SYMBOL_BITS-1:0] req_symbol,
   input  logic [RANK_BITS-1:0]   req_rank,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SYMBOL_BITS-1:0] rsp_entry_symbol,
   output logic [LEN_BITS-1:0]    rsp_code_length,
   output logic [WORD_BITS-1:0]   rsp_code_word,
   output logic                   rsp_entry_valid,
   output logic [DIST_BITS-1:0]   rsp_distinct_count,
   output logic                   rsp_count_overflow,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_code_kind
);

   localparam int SYM_W = $clog2(ALPHABET_SIZE);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET_SIZE - 1);

   sctb_state_type        state_ff, state_in;
   logic                  kind_ff;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [SYM_W:0]        distinct_ff, distinct_in;
   logic                  ovf_ff, ovf_in;
   logic [SYM_W-1:0]      s_ff, s_in;
   logic [SYM_W-1:0]      t_ff, t_in;
   logic [SYM_W-1:0]      rank_ff, rank_in;
   logic [COUNT_BITS-1:0] cum_ff, cum_in;
   logic [COUNT_BITS-1:0] cnt_s_ff, cnt_s_in;
   logic [SYM_W-1:0]      ld_addr_ff, ld_addr_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sctb_entry_type        rsp_entry_ff, rsp_entry_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [DIST_BITS-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  accept;
   sctb_opcode_type       op;
   logic                  h_clear, h_wr_en;
   logic [SYM_W-1:0]      h_rd_addr;
   logic [COUNT_BITS-1:0] h_rd_data;
   logic                  t_wr_en, t_rd_en;
   sctb_entry_type        t_wr_data, t_rd_data;
   logic                  div_start, div_done;
   sctb_code_type         div_code;
   logic                  precedes;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign op        = sctb_opcode_type'(req_opcode);
   assign csr_ready = 1'b1;

   sctb_hist #(.ALPHABET_SIZE(ALPHABET_SIZE), .COUNT_BITS(COUNT_BITS)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .clear   (h_clear),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data),
      .wr_en   (h_wr_en),
      .wr_addr (ld_addr_ff),
      .wr_data (h_rd_data + COUNT_BITS'(1))
   );

   sctb_table #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_table (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (rank_ff),
      .wr_data (t_wr_data),
      .rd_en   (t_rd_en),
      .rd_addr (req_rank[SYM_W-1:0]),
      .rd_data (t_rd_data)
   );

   sctb_div #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .kind  (kind_ff),
      .freq  (cnt_s_ff),
      .cum   (cum_ff),
      .total (total_ff),
      .done  (div_done),
      .code  (div_code)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
      end else if (csr_valid) begin
         kind_ff <= csr_code_kind;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         distinct_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         distinct_ff  <= distinct_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      t_ff         <= t_in;
      rank_ff      <= rank_in;
      cum_ff       <= cum_in;
      cnt_s_ff     <= cnt_s_in;
      ld_addr_ff   <= ld_addr_in;
      hit_ff       <= hit_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // A scanned symbol ranks ahead on a higher count, or an equal count and lower value.
   assign precedes = (h_rd_data > cnt_s_ff) || ((h_rd_data == cnt_s_ff) && (t_ff < s_ff));

   assign t_wr_data.symbol = SYMBOL_BITS'(s_ff);
   assign t_wr_data.code   = div_code;

   // Sequencer: next state, memory controls and datapath updates.
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      distinct_in  = distinct_ff;
      ovf_in       = ovf_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      rank_in      = rank_ff;
      cum_in       = cum_ff;
      cnt_s_in     = cnt_s_ff;
      ld_addr_in   = ld_addr_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_entry_in = rsp_entry_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      h_clear      = 1'b0;
      h_wr_en      = 1'b0;
      h_rd_addr    = req_symbol[SYM_W-1:0];
      t_wr_en      = 1'b0;
      t_rd_en      = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_LOAD: begin
                     if ({1'b0, req_symbol} < (SYMBOL_BITS + 1)'(ALPHABET_SIZE)) begin
                        if (total_ff == COUNT_MAX) begin
                           ovf_in = 1'b1;
                        end else begin
                           total_in   = total_ff + COUNT_BITS'(1);
                           ld_addr_in = req_symbol[SYM_W-1:0];
                           state_in   = ST_LD_WR;
                        end
                     end
                  end
                  OP_BUILD: begin
                     s_in        = '0;
                     distinct_in = '0;
                     state_in    = ST_B_FETCH;
                  end
                  OP_READ: begin
                     t_rd_en  = 1'b1;
                     hit_in   = (DIST_BITS'(req_rank) < DIST_BITS'(distinct_ff));
                     state_in = ST_RD_OUT;
                  end
                  OP_CLEAR: begin
                     h_clear     = 1'b1;
                     total_in    = '0;
                     distinct_in = '0;
                     ovf_in      = 1'b0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_WR: begin
            h_wr_en  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_entry_in = hit_ff ? t_rd_data : '0;
               rsp_dist_in  = DIST_BITS'(distinct_ff);
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_B_FETCH: begin
            h_rd_addr = s_ff;
            state_in  = ST_B_CAPT;
         end
         ST_B_CAPT: begin
            h_rd_addr = '0;
            cnt_s_in  = h_rd_data;
            if (h_rd_data == '0) begin
               s_in     = s_ff + SYM_W'(1);
               state_in = (s_ff == LAST_SYM) ? ST_IDLE : ST_B_FETCH;
            end else begin
               t_in     = '0;
               rank_in  = '0;
               cum_in   = '0;
               state_in = ST_B_SCAN;
            end
         end
         ST_B_SCAN: begin
            h_rd_addr = t_ff + SYM_W'(1);
            t_in      = t_ff + SYM_W'(1);
            if (precedes) begin
               rank_in = rank_ff + SYM_W'(1);
               cum_in  = cum_ff + h_rd_data;
            end
            if (t_ff == LAST_SYM) begin
               state_in = ST_B_DIV;
            end
         end
         ST_B_DIV: begin
            div_start = 1'b1;
            state_in  = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            if (div_done) begin
               t_wr_en     = 1'b1;
               distinct_in = distinct_ff + (SYM_W + 1)'(1);
               s_in        = s_ff + SYM_W'(1);
               state_in    = (s_ff == LAST_SYM) ? ST_IDLE : ST_B_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_symbol   = rsp_entry_ff.symbol;
   assign rsp_code_length    = rsp_entry_ff.code.len;
   assign rsp_code_word      = rsp_entry_ff.code.word;
   assign rsp_entry_valid    = rsp_hit_ff;
   assign rsp_distinct_count = rsp_dist_ff;
   assign rsp_count_overflow = rsp_ovf_ff;

   // An empty histogram can never have produced a ranked symbol.
   assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) |-> (distinct_ff == '0))
      else $error("distinct count nonzero with empty histogram");

   // The ranked count never exceeds the alphabet.
   assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= (SYM_W + 1)'(ALPHABET_SIZE))
      else $error("distinct count beyond alphabet size");

   // A load write-back is followed directly by the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LD_WR) |=> (state_ff == ST_IDLE))
      else $error("load write-back did not return to idle");

   // A miss carries an empty code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_entry_ff == '0))
      else $error("result for an absent rank carries a code");

endmodule
